// ----- design/assert_macros.svh -----
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ----- design/itr_pkg.sv -----
package itr_pkg;

    localparam int unsigned NUM_W    = 12;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned CMP_W    = 14;

    localparam logic [NUM_W-1:0] NUM_MAX = 12'd3999;

    // ascii codes
    localparam logic [LETTER_W-1:0] CH_M = 7'h4D;
    localparam logic [LETTER_W-1:0] CH_D = 7'h44;
    localparam logic [LETTER_W-1:0] CH_C = 7'h43;
    localparam logic [LETTER_W-1:0] CH_L = 7'h4C;
    localparam logic [LETTER_W-1:0] CH_X = 7'h58;
    localparam logic [LETTER_W-1:0] CH_V = 7'h56;
    localparam logic [LETTER_W-1:0] CH_I = 7'h49;

    typedef logic [1:0] t_place;
    typedef logic [3:0] t_digit;
    typedef logic [1:0] t_pos;

    localparam t_place PLACE_THOU = 2'd0;
    localparam t_place PLACE_HUND = 2'd1;
    localparam t_place PLACE_TENS = 2'd2;
    localparam t_place PLACE_UNIT = 2'd3;

    typedef struct packed {
        logic load;
        logic split;
        logic next_place;
        logic next_pos;
    } t_cmd;

    typedef struct packed {
        logic num_zero;
        logic digit_zero;
        logic last_pos;
        logic rem_zero;
    } t_status;

    function automatic logic [CMP_W-1:0] unit_value(input t_place p);
        logic [CMP_W-1:0] v;
        case (p)
            PLACE_THOU: v = 14'd1000;
            PLACE_HUND: v = 14'd100;
            PLACE_TENS: v = 14'd10;
            default:    v = 14'd1;
        endcase
        return v;
    endfunction

    function automatic logic [LETTER_W-1:0] one_letter(input t_place p);
        logic [LETTER_W-1:0] c;
        case (p)
            PLACE_THOU: c = CH_M;
            PLACE_HUND: c = CH_C;
            PLACE_TENS: c = CH_X;
            default:    c = CH_I;
        endcase
        return c;
    endfunction

    function automatic logic [LETTER_W-1:0] five_letter(input t_place p);
        logic [LETTER_W-1:0] c;
        case (p)
            PLACE_HUND: c = CH_D;
            PLACE_TENS: c = CH_L;
            PLACE_UNIT: c = CH_V;
            default:    c = CH_M;
        endcase
        return c;
    endfunction

    function automatic logic [LETTER_W-1:0] ten_letter(input t_place p);
        logic [LETTER_W-1:0] c;
        case (p)
            PLACE_HUND: c = CH_M;
            PLACE_TENS: c = CH_C;
            PLACE_UNIT: c = CH_X;
            default:    c = CH_M;
        endcase
        return c;
    endfunction

    // number of letters one digit produces
    function automatic logic [2:0] pattern_len(input t_digit d);
        logic [2:0] n;
        case (d)
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [LETTER_W-1:0] digit_letter(input t_place p, input t_digit d,
                                                         input t_pos pos);
        logic [LETTER_W-1:0] c;
        if (d == 4'd9) begin
            c = (pos == 2'd0) ? one_letter(p) : ten_letter(p);
        end else if (d == 4'd4) begin
            c = (pos == 2'd0) ? one_letter(p) : five_letter(p);
        end else if (d >= 4'd5) begin
            c = (pos == 2'd0) ? five_letter(p) : one_letter(p);
        end else begin
            c = one_letter(p);
        end
        return c;
    endfunction

endpackage

// ----- design/itr_dp.sv -----
module itr_dp (
    input  logic                              i_clk,
    input  logic [itr_pkg::NUM_W-1:0]         i_number,
    input  itr_pkg::t_cmd                     i_cmd,
    output itr_pkg::t_status                  o_status,
    output logic [itr_pkg::LETTER_W-1:0]      o_letter
);

    logic [itr_pkg::NUM_W-1:0] r_rem;
    itr_pkg::t_place           r_place;
    itr_pkg::t_digit           r_digit;
    itr_pkg::t_pos             r_pos;

    logic [itr_pkg::CMP_W-1:0] rem_ext;
    logic [itr_pkg::CMP_W-1:0] unit;
    logic [itr_pkg::CMP_W-1:0] sub;
    itr_pkg::t_digit           d_next;
    logic [itr_pkg::NUM_W-1:0] num_sat;

    // digit of the current place: largest k with k*unit <= remainder
    always_comb begin
        rem_ext = {{(itr_pkg::CMP_W - itr_pkg::NUM_W){1'b0}}, r_rem};
        unit    = itr_pkg::unit_value(r_place);
        d_next  = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_ext >= (itr_pkg::CMP_W'(k) * unit)) begin
                d_next = 4'(k);
            end
        end
        sub     = itr_pkg::CMP_W'(d_next) * unit;
        num_sat = (i_number > itr_pkg::NUM_MAX) ? itr_pkg::NUM_MAX : i_number;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= num_sat;
            r_place <= itr_pkg::PLACE_THOU;
        end else begin
            if (i_cmd.split) begin
                r_digit <= d_next;
                r_rem   <= r_rem - sub[itr_pkg::NUM_W-1:0];
                r_pos   <= 2'd0;
            end
            if (i_cmd.next_place) begin
                r_place <= r_place + 2'd1;
            end
            if (i_cmd.next_pos) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_comb begin
        o_status.num_zero   = (i_number == '0);
        o_status.digit_zero = (d_next == 4'd0);
        o_status.last_pos   = (({1'b0, r_pos} + 3'd1) == itr_pkg::pattern_len(r_digit));
        o_status.rem_zero   = (r_rem == '0);
    end

    assign o_letter = itr_pkg::digit_letter(r_place, r_digit, r_pos);

endmodule

// ----- design/itr_ctrl.sv -----
module itr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  itr_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output itr_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                // zero gives no letters, so it is simply dropped
                if (r_in_ready && i_in_valid && !i_status.num_zero) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                if (i_status.digit_zero) begin
                    o_cmd.next_place = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (i_status.last_pos) begin
                        if (i_status.rem_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.next_place = 1'b1;
                            n_state          = S_SPLIT;
                        end
                    end else begin
                        o_cmd.next_pos = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= (n_state == S_EMIT);
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ----- design/integer_to_roman_serializer.sv -----
// order: the number is loaded, then each decimal place is split from the thousands down
//   to the first nonzero digit before the first letter is valid
// throughput: one letter per cycle within a digit while the receiver is ready; a number
//   is not taken while letters remain, and the next number is taken after its last letter
// reset: synchronous active low, returns the controller to idle; zero gives no letters
`include "assert_macros.svh"

module integer_to_roman_serializer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [itr_pkg::NUM_W-1:0]    i_number,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [itr_pkg::LETTER_W-1:0] o_letter,
    output logic                         o_last_letter
);

    itr_pkg::t_cmd    cmd;
    itr_pkg::t_status status;
    logic             out_last_beat;
    logic             in_zero_beat;

    itr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    itr_dp u_dp (
        .i_clk    (i_clk),
        .i_number (i_number),
        .i_cmd    (cmd),
        .o_status (status),
        .o_letter (o_letter)
    );

    // last letter of the numeral: final letter of a digit with nothing left below it
    assign o_last_letter = status.last_pos && status.rem_zero;

    assign out_last_beat = o_out_valid && i_out_ready && o_last_letter;
    assign in_zero_beat  = i_in_valid && o_in_ready && (i_number == '0);

    `ASSERT_NEVER(a_ready_and_valid, i_clk, i_rst_n, o_in_ready && o_out_valid)
    `ASSERT_HOLDS(a_idle_after_last, i_clk, i_rst_n, out_last_beat |=> o_in_ready)
    `ASSERT_HOLDS(a_zero_dropped, i_clk, i_rst_n, in_zero_beat |=> o_in_ready)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD    = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int RX_HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 170;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 24;
    localparam string PREDICTED  = "?";

    typedef struct packed {
        logic [itr_pkg::LETTER_W-1:0] letter;
        logic                         is_last;
    } t_letter_beat;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic [itr_pkg::NUM_W-1:0]    i_number      = '0;
    logic                         i_out_ready   = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [itr_pkg::LETTER_W-1:0] o_letter;
    logic                         o_last_letter;

    t_letter_beat letters_due[$];
    int unsigned  fail_count    = 0;
    int unsigned  stall_cycles  = 0;
    int unsigned  tx_idle_pct   = 0;
    int unsigned  rx_idle_pct   = 0;
    bit           hold_request  = 1'b0;

    // directed numbers; a spelling of "?" means the row goes through the predictor
    logic [itr_pkg::NUM_W-1:0] directed_numbers [DIRECTED_ROWS] = '{
        12'd1,    12'd3999, 12'd4000, 12'd4095, 12'd0,    12'd3888,
        12'd4,    12'd9,    12'd40,   12'd90,   12'd400,  12'd900,
        12'd5,    12'd8,    12'd3,    12'd1000, 12'd3000, 12'd0,
        12'd1994, 12'd444,  12'd2048, 12'd1365, 12'd2730, 12'd76
    };
    string directed_spelling [DIRECTED_ROWS] = '{
        "I",    "MMMCMXCIX", "MMMCMXCIX", "MMMCMXCIX", "",  "MMMDCCCLXXXVIII",
        "IV",   "IX",        "XL",        "XC",        "CD", "CM",
        "V",    "VIII",      "III",       "M",         "MMM", "",
        "?",    "?",         "?",         "?",         "?",  "?"
    };

    integer_to_roman_serializer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_number      (i_number),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_letter      (o_letter),
        .o_last_letter (o_last_letter)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // spell the number and queue one expected beat per letter
    function automatic void predict_letters(input logic [itr_pkg::NUM_W-1:0] raw);
        logic [itr_pkg::LETTER_W-1:0] spelled[$];
        logic [itr_pkg::LETTER_W-1:0] one_ch, five_ch, ten_ch;
        int unsigned value, digit;
        value = 32'((raw > itr_pkg::NUM_MAX) ? itr_pkg::NUM_MAX : raw);
        repeat (value / 1000) spelled.push_back(itr_pkg::CH_M);
        for (int place = 0; place < 3; place++) begin
            case (place)
                0: begin
                    digit = (value / 100) % 10;
                    one_ch = itr_pkg::CH_C; five_ch = itr_pkg::CH_D; ten_ch = itr_pkg::CH_M;
                end
                1: begin
                    digit = (value / 10) % 10;
                    one_ch = itr_pkg::CH_X; five_ch = itr_pkg::CH_L; ten_ch = itr_pkg::CH_C;
                end
                default: begin
                    digit = value % 10;
                    one_ch = itr_pkg::CH_I; five_ch = itr_pkg::CH_V; ten_ch = itr_pkg::CH_X;
                end
            endcase
            if (digit == 9) begin
                spelled.push_back(one_ch);
                spelled.push_back(ten_ch);
            end else if (digit == 4) begin
                spelled.push_back(one_ch);
                spelled.push_back(five_ch);
            end else begin
                if (digit >= 5) spelled.push_back(five_ch);
                repeat (digit % 5) spelled.push_back(one_ch);
            end
        end
        for (int k = 0; k < spelled.size(); k++)
            letters_due.push_back('{spelled[k], k == spelled.size() - 1});
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    // offer one number, called and returning at a falling edge
    task automatic send_number(input logic [itr_pkg::NUM_W-1:0] value, input string spelled);
        byte ch;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number   <= value;
        do @(posedge i_clk); while (!o_in_ready);
        if (spelled == PREDICTED) begin
            predict_letters(value);
        end else begin
            for (int k = 0; k < spelled.len(); k++) begin
                ch = spelled[k];
                letters_due.push_back('{ch[itr_pkg::LETTER_W-1:0], k == spelled.len() - 1});
            end
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (letters_due.size() != 0) @(negedge i_clk);
    endtask

    // receiver: random back-pressure, or a long hold when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_letter_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (letters_due.size() == 0) begin
                note_failure($sformatf("unexpected beat letter %c (0x%0h) last %0b",
                                       o_letter, o_letter, o_last_letter));
            end else begin
                want = letters_due.pop_front();
                if (o_letter !== want.letter)
                    note_failure($sformatf("letter expected %c (0x%0h) got %c (0x%0h)",
                                           want.letter, want.letter, o_letter, o_letter));
                if (o_last_letter !== want.is_last)
                    note_failure($sformatf("last flag on %c expected %0b got %0b",
                                           want.letter, want.is_last, o_last_letter));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [itr_pkg::NUM_W-1:0] value;
        int unsigned roll, sent;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 36;
        rx_idle_pct = 71;
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_number(directed_numbers[r], directed_spelling[r]);

        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 71 : 0;
            rx_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 36 : 0;
            // block stops taking numbers behind a stalled receiver
            if (phase == 2) hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 4) begin
                    value = '0;
                end else if (roll < 10) begin
                    value = itr_pkg::NUM_W'($urandom_range(4095, 4000));
                end else if (roll < 35) begin
                    // lean on subtractive pairs and long runs
                    value = itr_pkg::NUM_W'($urandom_range(3) * 1000);
                    for (int p = 100; p >= 1; p = p / 10)
                        value += itr_pkg::NUM_W'(p * (($urandom_range(1) == 0) ?
                                 $urandom_range(9) :
                                 4 + 4 * $urandom_range(1) + $urandom_range(1)));
                end else begin
                    value = itr_pkg::NUM_W'($urandom_range(3999, 1));
                end
                send_number(value, PREDICTED);
                if (value != 0) sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && letters_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/itr_pkg.sv
design/itr_dp.sv
design/itr_ctrl.sv
design/integer_to_roman_serializer.sv
bench/testbench.sv
